### rtl/sbc_pkg.sv
// Shared types, constants and codes for the small bytecode core.
`timescale 1ns / 1ps
package sbc_pkg;

	// Fixed sizes of the machine
	localparam int NUM_REGS   = 8;
	localparam int PROG_WORDS = 8192;
	localparam int CALL_DEPTH = 16;
	localparam int DATA_DEPTH = 16;
	localparam int REG_W      = 32;
	localparam int RIDX_W     = 3;
	localparam int PC_W       = 14;
	localparam int ADDR_W     = 13;
	localparam int WORD_W     = 16;
	localparam int CODE_W     = 8;
	localparam int OPC_W      = 5;

	localparam logic [REG_W-1:0]  BUDGET_RESET = 32'd1000000;
	localparam logic [CODE_W-1:0] CODE_ABORT   = 8'hFF;

	// Command word opcodes
	typedef enum logic [1:0] {
		OP_WRREG = 2'd0,
		OP_START = 2'd1,
		OP_WORD  = 2'd2,
		OP_RDREG = 2'd3
	} sbc_op_t;

	// Major instruction codes (bits 15..11)
	localparam logic [OPC_W-1:0] T_BL_LO  = 5'd0;
	localparam logic [OPC_W-1:0] T_BL_HI  = 5'd3;
	localparam logic [OPC_W-1:0] T_B_LO   = 5'd4;
	localparam logic [OPC_W-1:0] T_B_HI   = 5'd7;
	localparam logic [OPC_W-1:0] T_SK_LO  = 5'd8;
	localparam logic [OPC_W-1:0] T_SK_HI  = 5'd11;
	localparam logic [OPC_W-1:0] T_ADDI   = 5'd12;
	localparam logic [OPC_W-1:0] T_SUBI   = 5'd13;
	localparam logic [OPC_W-1:0] T_MOVI8  = 5'd14;
	localparam logic [OPC_W-1:0] T_MOVI24 = 5'd15;
	localparam logic [OPC_W-1:0] T_GRP0   = 5'd16;
	localparam logic [OPC_W-1:0] T_GRP1   = 5'd17;
	localparam logic [OPC_W-1:0] T_EXIT   = 5'd31;

	// Register group sub-operations (bits 11..8)
	typedef enum logic [3:0] {
		SUB_MOV    = 4'd0,
		SUB_NOT    = 4'd1,
		SUB_ADD    = 4'd2,
		SUB_SUB    = 4'd3,
		SUB_AND    = 4'd4,
		SUB_ORR    = 4'd5,
		SUB_XOR    = 4'd6,
		SUB_LSL    = 4'd7,
		SUB_LSR    = 4'd8,
		SUB_SKREG  = 4'd9,
		SUB_LSLI   = 4'd10,
		SUB_LSRI   = 4'd11,
		SUB_PUSH   = 4'd12,
		SUB_POP    = 4'd13,
		SUB_RET    = 4'd14,
		SUB_MOVI32 = 4'd15
	} sbc_sub_t;

	// Skip conditions
	typedef enum logic [1:0] {
		CC_EQ = 2'd0,
		CC_NE = 2'd1,
		CC_LT = 2'd2,
		CC_GE = 2'd3
	} sbc_cc_t;

	// Pending extension word kinds
	typedef enum logic [1:0] {
		EXT_NONE  = 2'd0,
		EXT_IMM24 = 2'd1,
		EXT_LO32  = 2'd2,
		EXT_HI32  = 2'd3
	} sbc_ext_t;

	typedef struct packed {
		sbc_ext_t          kind;
		logic [RIDX_W-1:0] ridx;
	} sbc_pend_t;

	// Run control state
	typedef struct packed {
		logic [PC_W-1:0]   pc;
		sbc_pend_t         pend;
		logic [REG_W-1:0]  steps;
		logic              run;
		logic [CODE_W-1:0] code;
	} sbc_ctl_t;

	// Storage updates requested by the execute logic
	typedef struct packed {
		logic              rf_we;
		logic [RIDX_W-1:0] rf_waddr;
		logic [REG_W-1:0]  rf_wdata;
		logic              cs_push;
		logic [PC_W-1:0]   cs_wdata;
		logic              ds_push;
		logic [REG_W-1:0]  ds_wdata;
	} sbc_act_t;

endpackage

### rtl/sbc_cmd_if.sv
// Command channel: valid/ready handshake with the command word payload.
`timescale 1ns / 1ps
interface sbc_cmd_if;
	logic                              valid;
	logic                              ready;
	sbc_pkg::sbc_op_t                  opcode;
	logic [sbc_pkg::RIDX_W-1:0]        reg_index;
	logic [sbc_pkg::REG_W-1:0]         register_value;
	logic [sbc_pkg::WORD_W-1:0]        instruction_word;

	modport source (output valid, opcode, reg_index, register_value, instruction_word,
		input ready);
	modport sink (input valid, opcode, reg_index, register_value, instruction_word,
		output ready);
endinterface

### rtl/sbc_rsp_if.sv
// Response channel: valid/ready handshake with the status word payload.
`timescale 1ns / 1ps
interface sbc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [sbc_pkg::ADDR_W-1:0]        fetch_address;
	logic                              running;
	logic [sbc_pkg::CODE_W-1:0]        exit_code;
	logic [sbc_pkg::REG_W-1:0]         read_value;

	modport source (output valid, fetch_address, running, exit_code, read_value,
		input ready);
	modport sink (input valid, fetch_address, running, exit_code, read_value,
		output ready);
endinterface

### rtl/sbc_exec.sv
// Execute logic: next run state and storage updates for one command word.
`timescale 1ns / 1ps
module sbc_exec #(
	parameter int CALL_DEPTH = sbc_pkg::CALL_DEPTH,
	parameter int DATA_DEPTH = sbc_pkg::DATA_DEPTH,
	localparam int CDW = $clog2(CALL_DEPTH + 1),
	localparam int DDW = $clog2(DATA_DEPTH + 1)
) (
	input  sbc_pkg::sbc_op_t                 op,
	input  logic [sbc_pkg::RIDX_W-1:0]       idx,
	input  logic [sbc_pkg::REG_W-1:0]        val,
	input  logic [sbc_pkg::WORD_W-1:0]       word,
	input  logic [sbc_pkg::REG_W-1:0]        opa,
	input  logic [sbc_pkg::REG_W-1:0]        opb,
	input  logic [sbc_pkg::PC_W-1:0]         cs_top,
	input  logic [sbc_pkg::REG_W-1:0]        ds_top,
	input  logic [sbc_pkg::REG_W-1:0]        budget,
	input  sbc_pkg::sbc_ctl_t                ctl_q,
	input  logic [CDW-1:0]                   cdep_q,
	input  logic [DDW-1:0]                   ddep_q,
	output sbc_pkg::sbc_ctl_t                ctl_d,
	output logic [CDW-1:0]                   cdep_d,
	output logic [DDW-1:0]                   ddep_d,
	output sbc_pkg::sbc_act_t                act,
	output logic [sbc_pkg::REG_W-1:0]        read_val
);

	localparam logic [sbc_pkg::PC_W-1:0] PROG_END = sbc_pkg::PC_W'(sbc_pkg::PROG_WORDS);
	localparam logic [CDW-1:0]           CS_FULL  = CDW'(CALL_DEPTH);
	localparam logic [DDW-1:0]           DS_FULL  = DDW'(DATA_DEPTH);

	logic [sbc_pkg::OPC_W-1:0]  t;
	sbc_pkg::sbc_sub_t          sub;
	logic [7:0]                 imm;
	logic [sbc_pkg::REG_W-1:0]  imm32;
	logic [sbc_pkg::PC_W-1:0]   pc1;
	logic [sbc_pkg::PC_W-1:0]   pc2;
	logic [sbc_pkg::PC_W-1:0]   pc3;
	logic [sbc_pkg::PC_W-1:0]   jump;
	logic                       halt;
	logic [sbc_pkg::CODE_W-1:0] halt_code;
	logic                       chk;

	function automatic logic cond_holds(input logic [1:0] cc, input logic [31:0] a,
		input logic [31:0] b);
		logic r;
		case (sbc_pkg::sbc_cc_t'(cc))
			sbc_pkg::CC_EQ: r = (a == b);
			sbc_pkg::CC_NE: r = (a != b);
			sbc_pkg::CC_LT: r = (a < b);
			default:        r = (a >= b);
		endcase
		return r;
	endfunction

	// Decode fields
	assign t     = word[15:11];
	assign sub   = sbc_pkg::sbc_sub_t'(word[11:8]);
	assign imm   = word[7:0];
	assign imm32 = {24'd0, imm};
	assign pc1   = ctl_q.pc + sbc_pkg::PC_W'(1);
	assign pc2   = ctl_q.pc + sbc_pkg::PC_W'(2);
	assign pc3   = ctl_q.pc + sbc_pkg::PC_W'(3);
	assign jump  = {1'b0, word[12:0]};

	// Execute one command word
	always_comb begin
		ctl_d     = ctl_q;
		cdep_d    = cdep_q;
		ddep_d    = ddep_q;
		act       = '0;
		read_val  = '0;
		halt      = 1'b0;
		halt_code = sbc_pkg::CODE_ABORT;
		chk       = 1'b0;
		act.rf_waddr = word[10:8];
		case (op)
			sbc_pkg::OP_WRREG: begin
				act.rf_we    = 1'b1;
				act.rf_waddr = idx;
				act.rf_wdata = val;
			end
			sbc_pkg::OP_START: begin
				ctl_d.pc    = '0;
				ctl_d.pend  = '0;
				ctl_d.steps = '0;
				ctl_d.run   = 1'b1;
				ctl_d.code  = sbc_pkg::CODE_ABORT;
				cdep_d      = '0;
				ddep_d      = '0;
				chk         = 1'b1;
			end
			sbc_pkg::OP_WORD: begin
				if (ctl_q.run) begin
					chk = 1'b1;
					ctl_d.pc = pc1;
					if (ctl_q.pend.kind != sbc_pkg::EXT_NONE) begin
						// Extension word of a wide immediate load
						act.rf_we    = 1'b1;
						act.rf_waddr = ctl_q.pend.ridx;
						ctl_d.pend   = '0;
						case (ctl_q.pend.kind)
							sbc_pkg::EXT_IMM24: act.rf_wdata = opa + {8'd0, word, 8'd0};
							sbc_pkg::EXT_LO32: begin
								act.rf_wdata    = {16'd0, word};
								ctl_d.pend.kind = sbc_pkg::EXT_HI32;
								ctl_d.pend.ridx = ctl_q.pend.ridx;
							end
							default: act.rf_wdata = opa + {word, 16'd0};
						endcase
					end else begin
						ctl_d.steps = ctl_q.steps + 32'd1;
						case (t) inside
							[sbc_pkg::T_BL_LO:sbc_pkg::T_BL_HI]: begin
								if (cdep_q >= CS_FULL) begin
									halt = 1'b1;
								end else begin
									act.cs_push  = 1'b1;
									act.cs_wdata = pc1;
									cdep_d       = cdep_q + CDW'(1);
									ctl_d.pc     = jump;
								end
							end
							[sbc_pkg::T_B_LO:sbc_pkg::T_B_HI]: ctl_d.pc = jump;
							[sbc_pkg::T_SK_LO:sbc_pkg::T_SK_HI]: begin
								if (!cond_holds(t[1:0], opa, imm32))
									ctl_d.pc = pc2;
							end
							sbc_pkg::T_ADDI: begin
								act.rf_we    = 1'b1;
								act.rf_wdata = opa + imm32;
							end
							sbc_pkg::T_SUBI: begin
								act.rf_we    = 1'b1;
								act.rf_wdata = opa - imm32;
							end
							sbc_pkg::T_MOVI8: begin
								act.rf_we    = 1'b1;
								act.rf_wdata = imm32;
							end
							sbc_pkg::T_MOVI24: begin
								if (pc2 >= PROG_END) begin
									halt = 1'b1;
								end else begin
									act.rf_we       = 1'b1;
									act.rf_wdata    = imm32;
									ctl_d.pend.kind = sbc_pkg::EXT_IMM24;
									ctl_d.pend.ridx = word[10:8];
								end
							end
							sbc_pkg::T_GRP0, sbc_pkg::T_GRP1: begin
								act.rf_waddr = word[2:0];
								case (sub)
									sbc_pkg::SUB_MOV: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = opb;
									end
									sbc_pkg::SUB_NOT: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = ~opb;
									end
									sbc_pkg::SUB_ADD: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = opa + opb;
									end
									sbc_pkg::SUB_SUB: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = opa - opb;
									end
									sbc_pkg::SUB_AND: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = opa & opb;
									end
									sbc_pkg::SUB_ORR: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = opa | opb;
									end
									sbc_pkg::SUB_XOR: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = opa ^ opb;
									end
									sbc_pkg::SUB_LSL: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = (|opb[31:5]) ? '0 : (opa << opb[4:0]);
									end
									sbc_pkg::SUB_LSR: begin
										act.rf_we    = 1'b1;
										act.rf_wdata = (|opb[31:5]) ? '0 : (opa >> opb[4:0]);
									end
									sbc_pkg::SUB_SKREG: begin
										if (!cond_holds(word[7:6], opa, opb))
											ctl_d.pc = pc2;
									end
									sbc_pkg::SUB_LSLI: begin
										act.rf_we    = 1'b1;
										act.rf_waddr = word[7:5];
										act.rf_wdata = opa << word[4:0];
									end
									sbc_pkg::SUB_LSRI: begin
										act.rf_we    = 1'b1;
										act.rf_waddr = word[7:5];
										act.rf_wdata = opa >> word[4:0];
									end
									sbc_pkg::SUB_PUSH: begin
										if (ddep_q >= DS_FULL) begin
											halt = 1'b1;
										end else begin
											act.ds_push  = 1'b1;
											act.ds_wdata = opa;
											ddep_d       = ddep_q + DDW'(1);
										end
									end
									sbc_pkg::SUB_POP: begin
										if (ddep_q == '0) begin
											halt = 1'b1;
										end else begin
											act.rf_we    = 1'b1;
											act.rf_wdata = ds_top;
											ddep_d       = ddep_q - DDW'(1);
										end
									end
									sbc_pkg::SUB_RET: begin
										if (cdep_q == '0) begin
											halt = 1'b1;
										end else begin
											ctl_d.pc = cs_top;
											cdep_d   = cdep_q - CDW'(1);
										end
									end
									default: begin
										if (pc3 >= PROG_END) begin
											halt = 1'b1;
										end else begin
											ctl_d.pend.kind = sbc_pkg::EXT_LO32;
											ctl_d.pend.ridx = word[2:0];
										end
									end
								endcase
							end
							sbc_pkg::T_EXIT: begin
								halt      = 1'b1;
								halt_code = imm;
							end
							// Native calls and undefined codes abort
							default: halt = 1'b1;
						endcase
					end
				end
			end
			default: read_val = opa;
		endcase

		// Stop the run on an exit or a failed instruction
		if (halt) begin
			ctl_d.run  = 1'b0;
			ctl_d.code = halt_code;
			ctl_d.pend = '0;
		end

		// Check program end and budget before the next fetch
		if (chk && ctl_d.run && ctl_d.pend.kind == sbc_pkg::EXT_NONE &&
			(ctl_d.pc >= PROG_END || ctl_d.steps >= budget)) begin
			ctl_d.run  = 1'b0;
			ctl_d.code = sbc_pkg::CODE_ABORT;
			ctl_d.pend = '0;
		end
	end

endmodule

### rtl/small_bytecode_core_top.sv
// A command word accepted into the execute stage is executed there, and its result word is
// registered in the response register. Throughput: one command word per cycle; every
// instruction completes in the execute stage, on registered operands and stack tops.
// Only a stalled response channel holds off new command words.
// Reset (arst_n low) stops any run, sets exit code 255 and step budget 1000000,
// and makes all eight registers read as zero; both stacks start empty.
`timescale 1ns / 1ps
module small_bytecode_core_top #(
	parameter int CALL_DEPTH = sbc_pkg::CALL_DEPTH,
	parameter int DATA_DEPTH = sbc_pkg::DATA_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sbc_pkg::REG_W-1:0]   cfg_wdata,
	sbc_cmd_if.sink                     cmd,
	sbc_rsp_if.source                   rsp
);

	localparam int CDW = $clog2(CALL_DEPTH + 1);
	localparam int DDW = $clog2(DATA_DEPTH + 1);
	localparam int CIW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int DIW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

	// Run state
	sbc_pkg::sbc_ctl_t                 ctl_q, ctl_d, ctl_n;
	logic [CDW-1:0]                    cdep_q, cdep_d, cdep_n;
	logic [DDW-1:0]                    ddep_q, ddep_d, ddep_n;
	logic [sbc_pkg::REG_W-1:0]         budget_q;
	sbc_pkg::sbc_act_t                 act;
	logic [sbc_pkg::REG_W-1:0]         read_val;

	// Execute stage
	logic                              v_s1;
	sbc_pkg::sbc_op_t                  op_s1;
	logic [sbc_pkg::RIDX_W-1:0]        idx_s1;
	logic [sbc_pkg::REG_W-1:0]         val_s1;
	logic [sbc_pkg::WORD_W-1:0]        word_s1;
	logic [sbc_pkg::REG_W-1:0]         opa_s1, opb_s1;

	// Storage
	logic [sbc_pkg::REG_W-1:0]         rf_mem [sbc_pkg::NUM_REGS];
	logic [sbc_pkg::NUM_REGS-1:0]      rf_vld_q;
	logic [sbc_pkg::PC_W-1:0]          cs_mem [CALL_DEPTH];
	logic [sbc_pkg::REG_W-1:0]         ds_mem [DATA_DEPTH];
	logic [sbc_pkg::PC_W-1:0]          cs_top_q;
	logic [sbc_pkg::REG_W-1:0]         ds_top_q;

	// Response register
	logic                              rsp_v_q;
	logic [sbc_pkg::ADDR_W-1:0]        fetch_address_q;
	logic                              running_q;
	logic [sbc_pkg::CODE_W-1:0]        exit_code_q;
	logic [sbc_pkg::REG_W-1:0]         read_value_q;

	logic                              adv, acc;
	logic                              rf_we_n, cs_we_n, ds_we_n;
	logic [sbc_pkg::RIDX_W-1:0]        addr_a;
	logic [CIW-1:0]                    cs_wix, cs_rix;
	logic [DIW-1:0]                    ds_wix, ds_rix;
	logic [sbc_pkg::OPC_W-1:0]         in_t;
	sbc_pkg::sbc_sub_t                 in_sub;

	// Handshake: execute when the response register is free or draining
	assign adv       = v_s1 && (!rsp_v_q || rsp.ready);
	assign cmd.ready = !v_s1 || adv;
	assign acc       = cmd.valid && cmd.ready;

	sbc_exec #(
		.CALL_DEPTH (CALL_DEPTH),
		.DATA_DEPTH (DATA_DEPTH)
	) u_exec (
		.op       (op_s1),
		.idx      (idx_s1),
		.val      (val_s1),
		.word     (word_s1),
		.opa      (opa_s1),
		.opb      (opb_s1),
		.cs_top   (cs_top_q),
		.ds_top   (ds_top_q),
		.budget   (budget_q),
		.ctl_q    (ctl_q),
		.cdep_q   (cdep_q),
		.ddep_q   (ddep_q),
		.ctl_d    (ctl_d),
		.cdep_d   (cdep_d),
		.ddep_d   (ddep_d),
		.act      (act),
		.read_val (read_val)
	);

	// State as seen after this edge
	assign ctl_n   = adv ? ctl_d : ctl_q;
	assign cdep_n  = adv ? cdep_d : cdep_q;
	assign ddep_n  = adv ? ddep_d : ddep_q;
	assign rf_we_n = adv && act.rf_we;
	assign cs_we_n = adv && act.cs_push;
	assign ds_we_n = adv && act.ds_push;

	assign cs_wix = cdep_q[CIW-1:0];
	assign ds_wix = ddep_q[DIW-1:0];
	assign cs_rix = CIW'(cdep_n - CDW'(1));
	assign ds_rix = DIW'(ddep_n - DDW'(1));

	// Pick the first operand register of the incoming word
	assign in_t   = cmd.instruction_word[15:11];
	assign in_sub = sbc_pkg::sbc_sub_t'(cmd.instruction_word[11:8]);
	always_comb begin
		addr_a = cmd.reg_index;
		if (cmd.opcode == sbc_pkg::OP_WORD) begin
			if (ctl_n.pend.kind != sbc_pkg::EXT_NONE) begin
				addr_a = ctl_n.pend.ridx;
			end else if (in_t == sbc_pkg::T_GRP0 || in_t == sbc_pkg::T_GRP1) begin
				if (in_sub == sbc_pkg::SUB_LSLI || in_sub == sbc_pkg::SUB_LSRI)
					addr_a = cmd.instruction_word[7:5];
				else
					addr_a = cmd.instruction_word[2:0];
			end else begin
				addr_a = cmd.instruction_word[10:8];
			end
		end
	end

	// Register file: one write, two registered reads with bypass of the same-edge write
	always_ff @(posedge clk) begin
		if (rf_we_n)
			rf_mem[act.rf_waddr] <= act.rf_wdata;
		if (acc) begin
			opa_s1 <= (rf_we_n && act.rf_waddr == addr_a) ? act.rf_wdata :
				(rf_vld_q[addr_a] ? rf_mem[addr_a] : '0);
			opb_s1 <= (rf_we_n && act.rf_waddr == cmd.instruction_word[5:3]) ? act.rf_wdata :
				(rf_vld_q[cmd.instruction_word[5:3]] ? rf_mem[cmd.instruction_word[5:3]] : '0);
		end
	end

	// Mark registers written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we_n) begin
			rf_vld_q[act.rf_waddr] <= 1'b1;
		end
	end

	// Call and data stacks: keep the top entry registered
	always_ff @(posedge clk) begin
		if (cs_we_n)
			cs_mem[cs_wix] <= act.cs_wdata;
		cs_top_q <= (cs_we_n && cs_wix == cs_rix) ? act.cs_wdata : cs_mem[cs_rix];
		if (ds_we_n)
			ds_mem[ds_wix] <= act.ds_wdata;
		ds_top_q <= (ds_we_n && ds_wix == ds_rix) ? act.ds_wdata : ds_mem[ds_rix];
	end

	// Execute stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= cmd.opcode;
			idx_s1  <= cmd.reg_index;
			val_s1  <= cmd.register_value;
			word_s1 <= cmd.instruction_word;
		end
	end

	// Control state, step budget and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			ctl_q.pc   <= '0;
			ctl_q.pend <= '0;
			ctl_q.steps <= '0;
			ctl_q.run  <= 1'b0;
			ctl_q.code <= sbc_pkg::CODE_ABORT;
			cdep_q     <= '0;
			ddep_q     <= '0;
			budget_q   <= sbc_pkg::BUDGET_RESET;
		end else begin
			if (acc)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			ctl_q  <= ctl_n;
			cdep_q <= cdep_n;
			ddep_q <= ddep_n;
			if (cfg_we)
				budget_q <= cfg_wdata;
		end
	end

	// Response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (adv) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	// Response register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			fetch_address_q <= ctl_d.pc[sbc_pkg::ADDR_W-1:0];
			running_q       <= ctl_d.run;
			exit_code_q     <= ctl_d.code;
			read_value_q    <= read_val;
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.fetch_address = fetch_address_q;
	assign rsp.running       = running_q;
	assign rsp.exit_code     = exit_code_q;
	assign rsp.read_value    = read_value_q;

endmodule

### rtl/sbc_chk.sv
// Port checker for the bytecode core, bound to the top level.
`timescale 1ns / 1ps
module sbc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [sbc_pkg::ADDR_W-1:0]  rsp_fetch_address,
	input logic                        rsp_running,
	input logic [sbc_pkg::CODE_W-1:0]  rsp_exit_code,
	input logic [sbc_pkg::REG_W-1:0]   rsp_read_value
);

	// An empty response register never blocks commands
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> cmd_ready)
		else $error("command stalled with response register empty");

	// A running core always reports the abort code
	a_code_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_running |-> rsp_exit_code == sbc_pkg::CODE_ABORT)
		else $error("exit code not 255 while running");

	// A stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_fetch_address, rsp_running,
			rsp_exit_code, rsp_read_value}))
		else $error("stalled response word changed");

	// No response word right after reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("response valid right after reset");

	// A presented response word carries known values
	a_rsp_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !$isunknown({rsp_fetch_address, rsp_running, rsp_exit_code,
			rsp_read_value}))
		else $error("unknown value in response word");

endmodule

bind small_bytecode_core_top sbc_chk u_sbc_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_fetch_address (rsp.fetch_address),
	.rsp_running       (rsp.running),
	.rsp_exit_code     (rsp.exit_code),
	.rsp_read_value    (rsp.read_value)
);

### sim/tb_small_bytecode_core_top.sv
// Testbench for the small bytecode core: drives command words, predicts and checks status words.
`timescale 1ns / 1ps
module tb_small_bytecode_core_top;
	import sbc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned N_PHASES    = 10;
	localparam int unsigned PER_PHASE   = 115;
	localparam logic [OPC_W-1:0] T_BAD_LO = 5'd18;
	localparam logic [OPC_W-1:0] T_BAD_HI = 5'd29;
	localparam logic [OPC_W-1:0] T_NATIVE = 5'd30;

	typedef struct {
		sbc_op_t            op;
		logic [RIDX_W-1:0]  idx;
		logic [REG_W-1:0]   val;
		logic [WORD_W-1:0]  word;
	} command_t;

	typedef struct {
		logic [ADDR_W-1:0]  fetch_address;
		logic               running;
		logic [CODE_W-1:0]  exit_code;
		logic [REG_W-1:0]   read_value;
	} status_t;

	// Shadow copy of the core: predicts the status word of every command word
	class bytecode_shadow;
		logic [REG_W-1:0]  regs [NUM_REGS];
		logic [PC_W-1:0]   pc;
		logic [PC_W-1:0]   calls [CALL_DEPTH];
		int unsigned       call_sp;
		logic [REG_W-1:0]  dstack [DATA_DEPTH];
		int unsigned       data_sp;
		sbc_pend_t         pend;
		logic [REG_W-1:0]  steps;
		logic [REG_W-1:0]  budget;
		logic              running;
		logic [CODE_W-1:0] code;
		status_t           status_due [$];
		int unsigned       mismatches;
		int unsigned       compared;
		int unsigned       runs_started;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (calls[i]) calls[i] = '0;
			foreach (dstack[i]) dstack[i] = '0;
			pc = '0;
			call_sp = 0;
			data_sp = 0;
			pend = '{EXT_NONE, '0};
			steps = '0;
			budget = BUDGET_RESET;
			running = 1'b0;
			code = CODE_ABORT;
			mismatches = 0;
			compared = 0;
			runs_started = 0;
		endfunction

		function void stop_run(logic [CODE_W-1:0] c);
			running = 1'b0;
			code = c;
			pend = '{EXT_NONE, '0};
		endfunction

		// Stop before a fetch past the program or beyond the budget
		function void gate_fetch();
			if (pc >= PROG_WORDS)
				stop_run(CODE_ABORT);
			else if (steps >= budget)
				stop_run(CODE_ABORT);
		endfunction

		function bit cond_true(logic [1:0] cc, logic [REG_W-1:0] a, logic [REG_W-1:0] b);
			case (sbc_cc_t'(cc))
				CC_EQ: return a == b;
				CC_NE: return a != b;
				CC_LT: return a < b;
				default: return a >= b;
			endcase
		endfunction

		function void exec_group(logic [WORD_W-1:0] w);
			logic [RIDX_W-1:0] d;
			logic [RIDX_W-1:0] s;
			logic [RIDX_W-1:0] r5;
			logic [REG_W-1:0]  sh;
			d = w[2:0];
			s = w[5:3];
			r5 = w[7:5];
			sh = regs[s];
			case (sbc_sub_t'(w[11:8]))
				SUB_MOV: regs[d] = regs[s];
				SUB_NOT: regs[d] = ~regs[s];
				SUB_ADD: regs[d] = regs[d] + regs[s];
				SUB_SUB: regs[d] = regs[d] - regs[s];
				SUB_AND: regs[d] = regs[d] & regs[s];
				SUB_ORR: regs[d] = regs[d] | regs[s];
				SUB_XOR: regs[d] = regs[d] ^ regs[s];
				SUB_LSL: regs[d] = (sh >= 32) ? '0 : regs[d] << sh;
				SUB_LSR: regs[d] = (sh >= 32) ? '0 : regs[d] >> sh;
				SUB_SKREG: begin
					if (!cond_true(w[7:6], regs[d], regs[s]))
						pc = pc + 1;
				end
				SUB_LSLI: regs[r5] = regs[r5] << w[4:0];
				SUB_LSRI: regs[r5] = regs[r5] >> w[4:0];
				SUB_PUSH: begin
					if (data_sp >= DATA_DEPTH) begin
						stop_run(CODE_ABORT);
					end else begin
						dstack[data_sp] = regs[d];
						data_sp++;
					end
				end
				SUB_POP: begin
					if (data_sp == 0) begin
						stop_run(CODE_ABORT);
					end else begin
						data_sp--;
						regs[d] = dstack[data_sp];
					end
				end
				SUB_RET: begin
					if (call_sp == 0) begin
						stop_run(CODE_ABORT);
					end else begin
						call_sp--;
						pc = calls[call_sp];
					end
				end
				default: begin
					// The 32-bit load needs both extension words and the word after them inside the program
					if (pc + 2 >= PROG_WORDS)
						stop_run(CODE_ABORT);
					else
						pend = '{EXT_LO32, d};
				end
			endcase
		endfunction

		function void exec_instr(logic [WORD_W-1:0] w);
			logic [OPC_W-1:0]  t;
			logic [RIDX_W-1:0] r;
			logic [7:0]        imm;
			t = w[15:11];
			r = w[10:8];
			imm = w[7:0];
			steps = steps + 1;
			pc = pc + 1;
			if (t <= T_BL_HI) begin
				if (call_sp >= CALL_DEPTH) begin
					stop_run(CODE_ABORT);
					return;
				end
				calls[call_sp] = pc;
				call_sp++;
				pc = {1'b0, w[ADDR_W-1:0]};
			end else if (t <= T_B_HI) begin
				pc = {1'b0, w[ADDR_W-1:0]};
			end else if (t <= T_SK_HI) begin
				if (!cond_true(t[1:0], regs[r], {24'd0, imm}))
					pc = pc + 1;
			end else if (t == T_ADDI) begin
				regs[r] = regs[r] + imm;
			end else if (t == T_SUBI) begin
				regs[r] = regs[r] - imm;
			end else if (t == T_MOVI8) begin
				regs[r] = {24'd0, imm};
			end else if (t == T_MOVI24) begin
				if (pc + 1 >= PROG_WORDS) begin
					stop_run(CODE_ABORT);
					return;
				end
				regs[r] = {24'd0, imm};
				pend = '{EXT_IMM24, r};
			end else if (t == T_GRP0 || t == T_GRP1) begin
				exec_group(w);
			end else if (t == T_EXIT) begin
				stop_run(imm);
			end else begin
				stop_run(CODE_ABORT);
			end
		endfunction

		function void take_extension(logic [WORD_W-1:0] w);
			logic [RIDX_W-1:0] r;
			r = pend.ridx;
			pc = pc + 1;
			case (pend.kind)
				EXT_IMM24: begin
					regs[r] = regs[r] + {8'd0, w, 8'd0};
					pend = '{EXT_NONE, '0};
				end
				EXT_LO32: begin
					regs[r] = {16'd0, w};
					pend = '{EXT_HI32, r};
				end
				default: begin
					regs[r] = regs[r] + {w, 16'd0};
					pend = '{EXT_NONE, '0};
				end
			endcase
		endfunction

		// Note an accepted command word and queue its status word
		function void take_command(command_t c);
			status_t s;
			s.read_value = '0;
			case (c.op)
				OP_WRREG: regs[c.idx] = c.val;
				OP_START: begin
					pc = '0;
					call_sp = 0;
					data_sp = 0;
					pend = '{EXT_NONE, '0};
					steps = '0;
					running = 1'b1;
					code = CODE_ABORT;
					runs_started++;
					gate_fetch();
				end
				OP_WORD: begin
					if (running) begin
						if (pend.kind != EXT_NONE)
							take_extension(c.word);
						else
							exec_instr(c.word);
						if (running && pend.kind == EXT_NONE)
							gate_fetch();
					end
				end
				default: s.read_value = regs[c.idx];
			endcase
			s.fetch_address = pc[ADDR_W-1:0];
			s.running = running;
			s.exit_code = code;
			status_due.push_back(s);
		endfunction

		// Compare a status word with the oldest prediction
		function void match_status(status_t got);
			status_t want;
			if (status_due.size() == 0) begin
				$error("status word with nothing pending: fetch_address %0h running %0b",
					got.fetch_address, got.running);
				mismatches++;
				return;
			end
			want = status_due.pop_front();
			compared++;
			if (got.fetch_address !== want.fetch_address) begin
				$error("fetch_address: expected %0h, actual %0h",
					want.fetch_address, got.fetch_address);
				mismatches++;
			end
			if (got.running !== want.running) begin
				$error("running: expected %0b, actual %0b", want.running, got.running);
				mismatches++;
			end
			if (got.exit_code !== want.exit_code) begin
				$error("exit_code: expected %0h, actual %0h", want.exit_code, got.exit_code);
				mismatches++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %0h, actual %0h",
					want.read_value, got.read_value);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [REG_W-1:0] cfg_wdata;
	sbc_cmd_if        cmd_ch ();
	sbc_rsp_if        rsp_ch ();

	bytecode_shadow    shadow;
	logic [WORD_W-1:0] prog [PROG_WORDS];
	logic [REG_W-1:0]  budget_plan [N_PHASES];
	bit                steady;
	bit                rsp_hold_req;
	int unsigned       cycle_count = 0;
	int unsigned       n_settings = 0;

	small_bytecode_core_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (steady || p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] grp_word(sbc_sub_t sub, logic [7:0] low);
		return {T_GRP0[4:1], sub, low};
	endfunction

	// Random instruction with branch targets inside the program span
	function automatic logic [WORD_W-1:0] gen_instr(int unsigned span, bit stacky);
		int unsigned       p;
		logic [ADDR_W-1:0] tgt;
		logic [RIDX_W-1:0] r;
		logic [7:0]        imm;
		p = $urandom_range(0, 99);
		tgt = ADDR_W'($urandom_range(0, span - 1));
		r = RIDX_W'($urandom);
		imm = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		if (stacky && $urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 3))
				0: return {T_BL_LO[4:2], tgt};
				1: return grp_word(SUB_PUSH, {5'd0, r});
				2: return grp_word(SUB_POP, {5'd0, r});
				default: return grp_word(SUB_RET, 8'($urandom));
			endcase
		end
		if (p < 5)  return {T_BL_LO[4:2], tgt};
		if (p < 12) return {T_B_LO[4:2], tgt};
		if (p < 22) return {T_SK_LO[4:2], 2'($urandom), r, imm};
		if (p < 30) return {T_ADDI, r, imm};
		if (p < 36) return {T_SUBI, r, imm};
		if (p < 44) return {T_MOVI8, r, imm};
		if (p < 48) return {T_MOVI24, r, imm};
		if (p < 84) return grp_word(sbc_sub_t'($urandom_range(0, 15)), 8'($urandom));
		if (p < 88) return grp_word(SUB_RET, 8'($urandom));
		if (p < 91) return grp_word(SUB_PUSH, 8'($urandom));
		if (p < 93) return grp_word(SUB_POP, 8'($urandom));
		if (p < 95) return {T_EXIT, r, 8'($urandom)};
		if (p < 96) return {T_NATIVE, r, imm};
		if (p < 97) return {OPC_W'($urandom_range(T_BAD_LO, T_BAD_HI)), r, imm};
		return WORD_W'($urandom);
	endfunction

	function automatic command_t make_cmd(sbc_op_t op, logic [RIDX_W-1:0] idx,
		logic [REG_W-1:0] val, logic [WORD_W-1:0] w);
		command_t c;
		c.op = op;
		c.idx = idx;
		c.val = val;
		c.word = w;
		return c;
	endfunction

	// Mostly the program word the core asks for, with some noise mixed in
	function automatic command_t pick_command(output bit ignored);
		int unsigned       p;
		logic [REG_W-1:0]  v;
		logic [RIDX_W-1:0] r;
		logic [WORD_W-1:0] w;
		p = $urandom_range(0, 99);
		r = RIDX_W'($urandom);
		w = WORD_W'($urandom);
		v = ($urandom_range(0, 1) != 0) ? $urandom : REG_W'($urandom_range(0, 40));
		ignored = 1'b0;
		if (shadow.running) begin
			if (p < 87) return make_cmd(OP_WORD, r, $urandom, prog[shadow.pc[ADDR_W-1:0]]);
			if (p < 90) return make_cmd(OP_WORD, r, $urandom, w);
			if (p < 94) return make_cmd(OP_WRREG, r, v, w);
			if (p < 98) return make_cmd(OP_RDREG, r, $urandom, w);
			return make_cmd(OP_START, r, $urandom, w);
		end
		if (p < 50) return make_cmd(OP_START, r, $urandom, w);
		if (p < 75) return make_cmd(OP_RDREG, r, $urandom, w);
		if (p < 95) return make_cmd(OP_WRREG, r, v, w);
		ignored = 1'b1;
		return make_cmd(OP_WORD, r, $urandom, w);
	endfunction

	// Offer one command word after a random gap and hold it until taken
	task automatic send_cmd(command_t c);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= c.op;
		cmd_ch.reg_index <= c.idx;
		cmd_ch.register_value <= c.val;
		cmd_ch.instruction_word <= c.word;
		do @(posedge clk); while (!cmd_ch.ready);
		shadow.take_command(c);
	endtask

	task automatic send_op(sbc_op_t op, logic [RIDX_W-1:0] idx, logic [REG_W-1:0] val);
		send_cmd(make_cmd(op, idx, val, WORD_W'($urandom)));
	endtask

	// Feed program words until the run stops
	task automatic run_program();
		while (shadow.running)
			send_cmd(make_cmd(OP_WORD, RIDX_W'($urandom), $urandom,
				prog[shadow.pc[ADDR_W-1:0]]));
	endtask

	// Drop valid and wait until every status word is back
	task automatic wait_for_idle();
		cmd_ch.valid <= 1'b0;
		while (shadow.status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_budget(logic [REG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.budget = v;
		n_settings++;
	endtask

	// Status side: check accepted words and drive ready with random stalls
	initial begin
		bit          hi;
		int unsigned left;
		int unsigned hold;
		status_t     got;
		hi = 1'b1;
		left = 0;
		hold = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.fetch_address = rsp_ch.fetch_address;
				got.running = rsp_ch.running;
				got.exit_code = rsp_ch.exit_code;
				got.read_value = rsp_ch.read_value;
				shadow.match_status(got);
			end
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold != 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (steady) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				if (left == 0) begin
					hi = !hi;
					left = hi ? $urandom_range(1, 16) : pick_gap();
					if (left == 0) begin
						hi = 1'b1;
						left = $urandom_range(1, 16);
					end
				end
				left--;
				rsp_ch.ready <= hi;
			end
		end
	end

	// Command side: directed runs, then random phases
	initial begin
		command_t    c;
		bit          ignored;
		bit          stacky;
		int unsigned count;
		int unsigned span;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_WRREG;
		cmd_ch.reg_index = '0;
		cmd_ch.register_value = '0;
		cmd_ch.instruction_word = '0;
		steady = 1'b0;
		rsp_hold_req = 1'b0;
		shadow = new();
		budget_plan = '{32'd1, 32'hFFFF_FFFF, 32'd40, BUDGET_RESET, 32'd7,
			32'd300, 32'd2, 32'hFFFF_FFFF, 32'd120, 32'd25};
		foreach (prog[i]) prog[i] = gen_instr(64, 1'b0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extension words, shift by 32, both skips taken, call into a 32-bit load
		// that runs past the program end
		prog[0] = {T_MOVI24, 3'd1, 8'hAB};
		prog[1] = 16'hFFFF;
		prog[2] = grp_word(SUB_MOVI32, {5'd0, 3'd2});
		prog[3] = 16'h5678;
		prog[4] = 16'h1234;
		prog[5] = grp_word(SUB_LSL, {2'b00, 3'd5, 3'd2});
		prog[6] = {T_SK_LO[4:2], CC_EQ, 3'd7, 8'hFF};
		prog[7] = {T_EXIT, 3'd0, 8'h11};
		prog[8] = grp_word(SUB_SKREG, {CC_GE, 3'd7, 3'd1});
		prog[9] = {T_EXIT, 3'd0, 8'h22};
		prog[10] = {T_BL_LO[4:2], 13'd8189};
		prog[8189] = grp_word(SUB_MOVI32, {5'd0, 3'd3});
		send_op(OP_RDREG, 3'd0, $urandom);
		send_op(OP_WRREG, 3'd7, 32'hFFFF_FFFF);
		send_op(OP_WRREG, 3'd5, 32'd32);
		send_op(OP_START, 3'd0, $urandom);
		run_program();
		send_op(OP_RDREG, 3'd1, $urandom);
		send_op(OP_RDREG, 3'd2, $urandom);

		// Budget of two runs out after push and pop
		wait_for_idle();
		write_budget(32'd2);
		prog[0] = grp_word(SUB_PUSH, 8'd7);
		prog[1] = grp_word(SUB_POP, 8'd0);
		send_op(OP_START, 3'd0, $urandom);
		run_program();
		send_op(OP_RDREG, 3'd0, $urandom);

		// Zero budget stops the run at once
		wait_for_idle();
		write_budget(32'd0);
		send_op(OP_START, 3'd0, $urandom);

		// A 24-bit load whose extension would be the last word leaves its register alone
		wait_for_idle();
		write_budget(32'hFFFF_FFFF);
		prog[0] = {T_B_LO[4:2], 13'd8190};
		prog[8190] = {T_MOVI24, 3'd4, 8'h11};
		send_op(OP_START, 3'd0, $urandom);
		run_program();
		send_op(OP_RDREG, 3'd4, $urandom);

		// Random phases: fresh program and budget each time
		for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
			wait_for_idle();
			write_budget(budget_plan[ph]);
			steady = (ph == 3);
			stacky = (ph % 3 == 2);
			span = $urandom_range(16, 64);
			for (int unsigned a = 0; a < span + 4; a++)
				prog[a] = gen_instr(span, stacky);
			if (ph == 5)
				rsp_hold_req = 1'b1;
			count = 0;
			while (count < PER_PHASE) begin
				c = pick_command(ignored);
				send_cmd(c);
				if (!ignored)
					count++;
			end
		end
		wait_for_idle();

		$display("Covered %0d runs under %0d step budgets; %0d status words compared.",
			shadow.runs_started, n_settings, shadow.compared);
		if (shadow.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
